// ----- design/llc_pkg.sv -----
// shared constants and request and status codes for the linked list core
`default_nettype none

package llc_pkg;

  localparam int CAPACITY = 1024;
  localparam int PTR_W    = 11;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = 11;
  localparam int VAL_W    = 32;
  localparam int REQ_W    = 4;
  localparam int ST_W     = 2;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

  localparam logic [REQ_W-1:0] REQ_PREPEND    = 4'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND     = 4'd1;
  localparam logic [REQ_W-1:0] REQ_INS_BEFORE = 4'd2;
  localparam logic [REQ_W-1:0] REQ_INS_AFTER  = 4'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_FRONT  = 4'd4;
  localparam logic [REQ_W-1:0] REQ_DEL_BACK   = 4'd5;
  localparam logic [REQ_W-1:0] REQ_DEL_CUR    = 4'd6;
  localparam logic [REQ_W-1:0] REQ_FRONT      = 4'd7;
  localparam logic [REQ_W-1:0] REQ_BACK       = 4'd8;
  localparam logic [REQ_W-1:0] REQ_PREV       = 4'd9;
  localparam logic [REQ_W-1:0] REQ_NEXT       = 4'd10;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd11;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

endpackage

`default_nettype wire

// ----- design/llc_if.sv -----
// request and result channel interfaces of the linked list core
`default_nettype none

interface llc_req_if;
  import llc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
  modport monitor (input valid, input req_type, input value, input ready);
endinterface

interface llc_rsp_if;
  import llc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic [LEN_W-1:0]        list_length;
  logic signed [LEN_W-1:0] cursor_position;
  logic signed [VAL_W-1:0] front_value;
  logic signed [VAL_W-1:0] back_value;
  logic signed [VAL_W-1:0] cursor_value;

  modport source (output valid, output status, output list_length, output cursor_position,
                  output front_value, output back_value, output cursor_value, input ready);
  modport sink (input valid, input status, input list_length, input cursor_position,
                input front_value, input back_value, input cursor_value, output ready);
  modport monitor (input valid, input status, input list_length, input cursor_position,
                   input front_value, input back_value, input cursor_value, input ready);
endinterface

`default_nettype wire

// ----- design/linked_list_with_cursor_core.sv -----
// microcoded doubly linked list with cursor over a node pool memory
// sequencing: each request runs its microcode steps (a check alone if ignored or
//   refused), then shared steps that read head and tail and emit the result
// throughput: a new request is taken only after the result is emitted, since the
//   microcode steps through one read and one write port on each node memory
// reset: synchronous, empties the list and the free chain; node memory is not cleared
`default_nettype none

module linked_list_with_cursor_core (
  input  logic       clk,
  input  logic       rst,
  llc_req_if.sink    req,
  llc_rsp_if.source  rsp
);
  import llc_pkg::*;

  typedef logic [3:0] step_t;
  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [2:0] {R_CUR, R_FHEAD, R_DTGT, R_HEAD, R_TAIL} rsel_t;
  typedef enum logic [3:0] {
    A_NOP, A_CHK, A_INS_PQ, A_INS_WR, A_INS_LINK, A_DEL_WR, A_DEL_LINK,
    A_MOVE, A_CLEAR, A_CAP_FRONT, A_CAP_BACK, A_EMIT
  } act_t;
  typedef enum logic [1:0] {J_NEXT, J_FAIL, J_ALWAYS, J_DONE} jc_t;

  typedef struct packed {
    rsel_t rsel;
    act_t  act;
    jc_t   jc;
    step_t target;
  } ctl_t;

  localparam step_t S_INS0 = 4'd0;
  localparam step_t S_INS1 = 4'd1;
  localparam step_t S_INS2 = 4'd2;
  localparam step_t S_INS3 = 4'd3;
  localparam step_t S_DEL0 = 4'd4;
  localparam step_t S_DEL1 = 4'd5;
  localparam step_t S_DEL2 = 4'd6;
  localparam step_t S_MOV0 = 4'd7;
  localparam step_t S_MOV1 = 4'd8;
  localparam step_t S_CLR0 = 4'd9;
  localparam step_t S_BAD0 = 4'd10;
  localparam step_t S_FIN0 = 4'd11;
  localparam step_t S_FIN1 = 4'd12;
  localparam step_t S_FIN2 = 4'd13;
  localparam step_t S_FIN3 = 4'd14;

  function automatic ctl_t ucode(input step_t s);
    case (s)
      S_INS0:  return '{rsel: R_CUR,   act: A_CHK,       jc: J_FAIL,   target: S_FIN0};
      S_INS1:  return '{rsel: R_FHEAD, act: A_INS_PQ,    jc: J_NEXT,   target: S_FIN0};
      S_INS2:  return '{rsel: R_CUR,   act: A_INS_WR,    jc: J_NEXT,   target: S_FIN0};
      S_INS3:  return '{rsel: R_CUR,   act: A_INS_LINK,  jc: J_ALWAYS, target: S_FIN0};
      S_DEL0:  return '{rsel: R_DTGT,  act: A_CHK,       jc: J_FAIL,   target: S_FIN0};
      S_DEL1:  return '{rsel: R_CUR,   act: A_DEL_WR,    jc: J_NEXT,   target: S_FIN0};
      S_DEL2:  return '{rsel: R_CUR,   act: A_DEL_LINK,  jc: J_ALWAYS, target: S_FIN0};
      S_MOV0:  return '{rsel: R_CUR,   act: A_CHK,       jc: J_FAIL,   target: S_FIN0};
      S_MOV1:  return '{rsel: R_CUR,   act: A_MOVE,      jc: J_ALWAYS, target: S_FIN0};
      S_CLR0:  return '{rsel: R_CUR,   act: A_CLEAR,     jc: J_ALWAYS, target: S_FIN0};
      S_BAD0:  return '{rsel: R_CUR,   act: A_CHK,       jc: J_ALWAYS, target: S_FIN0};
      S_FIN0:  return '{rsel: R_HEAD,  act: A_NOP,       jc: J_NEXT,   target: S_FIN0};
      S_FIN1:  return '{rsel: R_TAIL,  act: A_CAP_FRONT, jc: J_NEXT,   target: S_FIN0};
      S_FIN2:  return '{rsel: R_CUR,   act: A_CAP_BACK,  jc: J_NEXT,   target: S_FIN0};
      S_FIN3:  return '{rsel: R_CUR,   act: A_EMIT,      jc: J_DONE,   target: S_FIN0};
      default: return '{rsel: R_CUR,   act: A_NOP,       jc: J_ALWAYS, target: S_FIN0};
    endcase
  endfunction

  function automatic step_t entry(input logic [REQ_W-1:0] r);
    case (r) inside
      [REQ_PREPEND:REQ_INS_AFTER]: return S_INS0;
      [REQ_DEL_FRONT:REQ_DEL_CUR]: return S_DEL0;
      [REQ_FRONT:REQ_NEXT]:        return S_MOV0;
      REQ_CLEAR:                   return S_CLR0;
      default:                     return S_BAD0;
    endcase
  endfunction

  // node pool
  logic [VAL_W-1:0] val_mem  [CAPACITY];
  logic [PTR_W-1:0] next_mem [CAPACITY];
  logic [PTR_W-1:0] prev_mem [CAPACITY];

  // sequencer and list state
  logic                    busy;
  step_t                   step;
  logic [REQ_W-1:0]        req_r;
  logic [VAL_W-1:0]        val_r;
  logic [ST_W-1:0]         status;
  ptr_t                    head;
  ptr_t                    tail;
  ptr_t                    cur;
  ptr_t                    fhead;
  ptr_t                    wmark;
  ptr_t                    n;
  ptr_t                    p;
  ptr_t                    q;
  logic                    used_free;
  logic signed [LEN_W-1:0] idx;
  logic [LEN_W-1:0]        count;
  logic [VAL_W-1:0]        front_v;
  logic [VAL_W-1:0]        back_v;
  logic [VAL_W-1:0]        rd_val;
  ptr_t                    rd_next;
  ptr_t                    rd_prev;

  // result register
  logic                    out_valid;
  logic [ST_W-1:0]         out_status;
  logic [LEN_W-1:0]        out_len;
  logic signed [LEN_W-1:0] out_pos;
  logic [VAL_W-1:0]        out_front;
  logic [VAL_W-1:0]        out_back;
  logic [VAL_W-1:0]        out_cur;

  ctl_t             ctl;
  ptr_t             raddr;
  ptr_t             dtgt;
  logic             bad;
  logic             full;
  logic             is_ins;
  logic             fail;
  logic             emit_ok;
  logic             emit;
  logic             val_we;
  logic             next_we;
  logic             prev_we;
  ptr_t             val_wa;
  ptr_t             next_wa;
  ptr_t             prev_wa;
  ptr_t             next_wd;
  ptr_t             prev_wd;

  assign ctl     = ucode(step);
  assign is_ins  = (req_r <= REQ_INS_AFTER);
  assign full    = (fhead == NIL) && (wmark == NIL);
  assign fail    = bad || (is_ins && full);
  assign emit_ok = !out_valid || rsp.ready;
  assign emit    = busy && (ctl.act == A_EMIT) && emit_ok;

  always_comb begin
    case (req_r) inside
      REQ_PREPEND, REQ_APPEND, REQ_CLEAR:                      bad = 1'b0;
      REQ_INS_BEFORE, REQ_INS_AFTER, REQ_DEL_CUR, REQ_PREV, REQ_NEXT:
                                                               bad = (cur == NIL);
      REQ_DEL_FRONT, REQ_DEL_BACK, REQ_FRONT, REQ_BACK:        bad = (count == '0);
      default:                                                 bad = 1'b1;
    endcase
  end

  always_comb begin
    case (req_r)
      REQ_DEL_FRONT: dtgt = head;
      REQ_DEL_BACK:  dtgt = tail;
      default:       dtgt = cur;
    endcase
  end

  always_comb begin
    case (ctl.rsel)
      R_FHEAD: raddr = fhead;
      R_DTGT:  raddr = dtgt;
      R_HEAD:  raddr = head;
      R_TAIL:  raddr = tail;
      default: raddr = cur;
    endcase
  end

  always_comb begin
    val_we  = 1'b0;
    next_we = 1'b0;
    prev_we = 1'b0;
    val_wa  = n;
    next_wa = n;
    prev_wa = n;
    next_wd = q;
    prev_wd = p;
    case (ctl.act)
      A_INS_WR: begin
        val_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      A_INS_LINK: begin
        next_we = (p != NIL);
        next_wa = p;
        next_wd = n;
        prev_we = (q != NIL);
        prev_wa = q;
        prev_wd = n;
      end
      A_DEL_WR: begin
        next_we = 1'b1;
        next_wd = fhead;
      end
      A_DEL_LINK: begin
        next_we = (p != NIL);
        next_wa = p;
        prev_we = (q != NIL);
        prev_wa = q;
      end
      A_CLEAR: begin
        next_we = (count != '0);
        next_wa = tail;
        next_wd = fhead;
      end
      default: begin
        val_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa[IDX_W-1:0]] <= val_r;
    if (next_we) next_mem[next_wa[IDX_W-1:0]] <= next_wd;
    if (prev_we) prev_mem[prev_wa[IDX_W-1:0]] <= prev_wd;
    rd_val  <= val_mem[raddr[IDX_W-1:0]];
    rd_next <= next_mem[raddr[IDX_W-1:0]];
    rd_prev <= prev_mem[raddr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= S_INS0;
      head      <= NIL;
      tail      <= NIL;
      cur       <= NIL;
      fhead     <= NIL;
      wmark     <= '0;
      idx       <= '1;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !emit) out_valid <= 1'b0;

      if (!busy) begin
        if (req.valid) begin
          busy  <= 1'b1;
          step  <= entry(req.req_type);
          req_r <= req.req_type;
          val_r <= req.value;
        end
      end else begin
        case (ctl.jc)
          J_NEXT:   step <= step + 1'b1;
          J_FAIL:   step <= fail ? ctl.target : step + 1'b1;
          J_ALWAYS: step <= ctl.target;
          default:  step <= step;
        endcase

        case (ctl.act)
          A_CHK: begin
            n <= dtgt;
            if (bad) status <= ST_IGNORED;
            else if (is_ins && full) status <= ST_FULL;
            else status <= ST_DONE;
          end
          A_INS_PQ: begin
            case (req_r)
              REQ_PREPEND: begin
                p <= NIL;
                q <= head;
              end
              REQ_APPEND: begin
                p <= tail;
                q <= NIL;
              end
              REQ_INS_BEFORE: begin
                p <= rd_prev;
                q <= cur;
              end
              default: begin
                p <= cur;
                q <= rd_next;
              end
            endcase
            if (fhead != NIL) begin
              n         <= fhead;
              used_free <= 1'b1;
            end else begin
              n         <= wmark;
              wmark     <= wmark + 1'b1;
              used_free <= 1'b0;
            end
          end
          A_INS_WR: begin
            if (used_free) fhead <= rd_next;
          end
          A_INS_LINK: begin
            if (p == NIL) head <= n;
            if (q == NIL) tail <= n;
            count <= count + 1'b1;
            if ((req_r == REQ_PREPEND && cur != NIL) || req_r == REQ_INS_BEFORE)
              idx <= idx + $signed(LEN_W'(1));
          end
          A_DEL_WR: begin
            p     <= rd_prev;
            q     <= rd_next;
            fhead <= n;
            count <= count - 1'b1;
            case (req_r)
              REQ_DEL_FRONT: begin
                if (cur == head) begin
                  cur <= NIL;
                  idx <= '1;
                end else if (cur != NIL) begin
                  idx <= idx - $signed(LEN_W'(1));
                end
              end
              REQ_DEL_BACK: begin
                if (cur == tail) begin
                  cur <= NIL;
                  idx <= '1;
                end
              end
              default: begin
                cur <= NIL;
                idx <= '1;
              end
            endcase
          end
          A_DEL_LINK: begin
            if (p == NIL) head <= q;
            if (q == NIL) tail <= p;
          end
          A_MOVE: begin
            case (req_r)
              REQ_FRONT: begin
                cur <= head;
                idx <= '0;
              end
              REQ_BACK: begin
                cur <= tail;
                idx <= $signed(count - LEN_W'(1));
              end
              REQ_PREV: begin
                if (idx == '0) begin
                  cur <= NIL;
                  idx <= '1;
                end else begin
                  cur <= rd_prev;
                  idx <= idx - $signed(LEN_W'(1));
                end
              end
              default: begin
                if ($unsigned(idx) == count - LEN_W'(1)) begin
                  cur <= NIL;
                  idx <= '1;
                end else begin
                  cur <= rd_next;
                  idx <= idx + $signed(LEN_W'(1));
                end
              end
            endcase
          end
          A_CLEAR: begin
            status <= ST_DONE;
            if (count != '0) begin
              fhead <= head;
              head  <= NIL;
              tail  <= NIL;
              count <= '0;
              cur   <= NIL;
              idx   <= '1;
            end
          end
          A_CAP_FRONT: front_v <= rd_val;
          A_CAP_BACK:  back_v <= rd_val;
          A_EMIT: begin
            if (emit_ok) begin
              busy       <= 1'b0;
              out_valid  <= 1'b1;
              out_status <= status;
              out_len    <= count;
              out_pos    <= idx;
              out_front  <= (count != '0) ? front_v : '1;
              out_back   <= (count != '0) ? back_v : '1;
              out_cur    <= (cur != NIL) ? rd_val : '1;
            end
          end
          default: begin
            busy <= 1'b1;
          end
        endcase
      end
    end
  end

  assign req.ready           = !busy;
  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.list_length     = out_len;
  assign rsp.cursor_position = out_pos;
  assign rsp.front_value     = $signed(out_front);
  assign rsp.back_value      = $signed(out_back);
  assign rsp.cursor_value    = $signed(out_cur);

endmodule

`default_nettype wire

// ----- design/llc_checker.sv -----
// port-level checks for the linked list core and their binding
`default_nettype none

module llc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [llc_pkg::ST_W-1:0]      rsp_status,
  input logic [llc_pkg::LEN_W-1:0]     rsp_list_length,
  input logic signed [llc_pkg::LEN_W-1:0] rsp_cursor_position,
  input logic signed [llc_pkg::VAL_W-1:0] rsp_cursor_value
);
  import llc_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one is in flight");

  a_full_means_all_used: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_list_length == LEN_W'(CAPACITY))
    else $error("refused insert while pool had free nodes");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_cursor_position == -11'sd1) ||
                  ($unsigned(rsp_cursor_position) < rsp_list_length))
    else $error("cursor position outside the list");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                $stable(rsp_list_length) && $stable(rsp_cursor_value))
    else $error("stalled result changed");

endmodule

bind linked_list_with_cursor_core llc_checker u_llc_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_status          (rsp.status),
  .rsp_list_length     (rsp.list_length),
  .rsp_cursor_position (rsp.cursor_position),
  .rsp_cursor_value    (rsp.cursor_value)
);

`default_nettype wire
